/* sv/lcbo_pkg.sv */
package lcbo_pkg;

  // Default width of the internal byte counter; results are reported on 32 bits.
  localparam int unsigned OFFSET_WIDTH = 32;

  localparam logic [7:0] NEWLINE = 8'h0a;

  typedef enum logic [1:0] {
    ENC_UTF8  = 2'd0,
    ENC_UTF16 = 2'd1,
    ENC_CP    = 2'd2
  } enc_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_LINE   = 2'd1,
    ST_COLUMN = 2'd2,
    ST_SPLIT  = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [31:0] target_line;
    logic [31:0] target_column;
  } item_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    status_e     status;
  } res_t;

  // Codepoint length from the leading ones of a lead byte. Counts outside
  // two to four (ASCII, stray continuation, 5+ ones) are one byte.
  function automatic logic [2:0] cp_len(input logic [7:0] b);
    logic [2:0] len;
    case (b) inside
      8'b110?????: len = 3'd2;
      8'b1110????: len = 3'd3;
      8'b11110???: len = 3'd4;
      default:     len = 3'd1;
    endcase
    return len;
  endfunction

endpackage

/* sv/lcbo_in_if.sv */
interface lcbo_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] target_line;
  logic [31:0] target_column;

  modport source (output valid, data_byte, first_byte, last_byte, target_line,
                  target_column, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, target_line,
                target_column, output ready);
endinterface

/* sv/lcbo_out_if.sv */
interface lcbo_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] byte_offset;
  logic [1:0]  status;

  modport source (output valid, byte_offset, status, input ready);
  modport sink (input valid, byte_offset, status, output ready);
endinterface

/* sv/lcbo_walk.sv */
module lcbo_walk
  import lcbo_pkg::*;
#(
  parameter int unsigned OffsetWidth = OFFSET_WIDTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  input  enc_e  enc_i,
  output logic  res_vld_o,
  output res_t  res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LINES,
    PH_COLUMN
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [31:0]            lines_q, lines_d;
  logic [31:0]            units_q, units_d;
  logic [OffsetWidth-1:0] pos_q, pos_d;
  logic [1:0]             skip_q, skip_d;

  logic [OffsetWidth-1:0] cur_pos, nxt_pos, off;
  logic [31:0]            lines_dec, u16;
  logic [2:0]             len;
  logic                   give;
  status_e                st;

  assign len = cp_len(item_i.data_byte);

  always_comb begin
    phase_d = phase_q;
    lines_d = lines_q;
    units_d = units_q;
    pos_d   = pos_q;
    skip_d  = skip_q;
    give    = 1'b0;
    off     = '0;
    st      = ST_OK;
    cur_pos = '0;
    nxt_pos = '0;
    lines_dec = '0;
    u16     = 32'd1;

    if (item_i.first_byte) begin
      lines_d = item_i.target_line;
      units_d = item_i.target_column;
      pos_d   = '0;
      skip_d  = '0;
      phase_d = (item_i.target_line != '0) ? PH_LINES : PH_COLUMN;
    end

    if (item_i.first_byte && item_i.target_line == '0 && item_i.target_column == '0) begin
      // column zero of line zero: offset zero at once
      give  = 1'b1;
      pos_d = OffsetWidth'(1);
    end else if (phase_d != PH_IDLE) begin
      cur_pos = pos_d;
      nxt_pos = cur_pos + OffsetWidth'(1);
      pos_d   = nxt_pos;
      lines_dec = lines_d - 32'd1;
      if (phase_d == PH_LINES) begin
        if (item_i.data_byte == NEWLINE && lines_dec == '0) begin
          lines_d = lines_dec;
          phase_d = PH_COLUMN;
          if (units_d == '0) begin
            give = 1'b1;
            off  = nxt_pos;
          end else if (item_i.last_byte) begin
            give = 1'b1;
            off  = nxt_pos;
            st   = ST_COLUMN;
          end
        end else begin
          if (item_i.data_byte == NEWLINE) begin
            lines_d = lines_dec;
          end
          if (item_i.last_byte) begin
            give = 1'b1;
            off  = nxt_pos;
            st   = ST_LINE;
          end
        end
      end else begin
        if (item_i.data_byte == NEWLINE) begin
          give = 1'b1;
          off  = cur_pos;
          st   = ST_COLUMN;
        end else if (skip_d != '0) begin
          skip_d = skip_d - 2'd1;
        end else if (enc_i == ENC_UTF8) begin
          units_d = units_d - 32'd1;
          if (units_d == '0) begin
            give = 1'b1;
            off  = nxt_pos;
          end
        end else begin
          if (enc_i == ENC_UTF16 && len == 3'd4) begin
            u16 = 32'd2;
          end
          if (units_d < u16) begin
            // one UTF-16 unit left but a surrogate pair comes
            give = 1'b1;
            off  = cur_pos;
            st   = ST_SPLIT;
          end else begin
            units_d = units_d - u16;
            skip_d  = 2'(len - 3'd1);
            if (units_d == '0) begin
              give = 1'b1;
              off  = cur_pos + OffsetWidth'(len);
            end
          end
        end
        if (!give && item_i.last_byte) begin
          give = 1'b1;
          off  = nxt_pos;
          st   = ST_COLUMN;
        end
      end
    end

    if (give) begin
      phase_d = PH_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      lines_q <= '0;
      units_q <= '0;
      pos_q   <= '0;
      skip_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      lines_q <= lines_d;
      units_q <= units_d;
      pos_q   <= pos_d;
      skip_q  <= skip_d;
    end
  end

  assign res_vld_o         = give;
  assign res_o.byte_offset = 32'(off);
  assign res_o.status      = st;

endmodule

/* sv/line_column_to_byte_offset.sv */
// line_column_to_byte_offset
// Finds the byte offset of an editor position (line, column) in a UTF-8 text.
// req_i carries the text one byte per request; the request with first_byte set
// also carries target_line and target_column, and last_byte marks the end.
// rsp_o returns at most one result per text: byte_offset and a status
// (ok, line past end, column past end of line, column splits a surrogate pair).
// cfg_we_i/cfg_wdata_i write the column unit: UTF-8 bytes, UTF-16 units or
// codepoints (code 3 acts as codepoints). Write it only while the block is idle.
// Throughput: one byte per cycle while rsp_o is not stalled. A request is latched
// in the input register at the edge that takes it, the walker evaluates it in
// the following cycle and its result lands in the output register once that
// register can take it; from then on the result is valid on rsp_o.
// A stalled rsp_o holding a result freezes the walker: the byte in the input
// register waits and req_i is held off until the result is taken.
// Reset: no text in progress, column unit UTF-16, both channels empty.
module line_column_to_byte_offset
  import lcbo_pkg::*;
#(
  parameter int unsigned OffsetWidth = OFFSET_WIDTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lcbo_in_if.sink          req_i,
  lcbo_out_if.source       rsp_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_wdata_i
);

  enc_e  enc_q;
  item_t item_q;
  logic  in_vld_q;
  res_t  res_q;
  logic  out_vld_q;

  logic  fire;
  logic  walk_vld;
  res_t  walk_res;

  // walker advances when the output register can take a result
  assign fire      = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= ENC_UTF16;
    end else if (cfg_we_i) begin
      enc_q <= enc_e'(cfg_wdata_i);
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      item_q.data_byte     <= req_i.data_byte;
      item_q.first_byte    <= req_i.first_byte;
      item_q.last_byte     <= req_i.last_byte;
      item_q.target_line   <= req_i.target_line;
      item_q.target_column <= req_i.target_column;
    end
  end

  lcbo_walk #(
    .OffsetWidth(OffsetWidth)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .enc_i    (enc_q),
    .res_vld_o(walk_vld),
    .res_o    (walk_res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire && walk_vld) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && walk_vld) begin
      res_q <= walk_res;
    end
  end

  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.byte_offset = res_q.byte_offset;
  assign rsp_o.status      = res_q.status;

  // a result only appears after the walker stepped
  a_rise_after_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(fire))
    else $error("result appeared without a walker step");

  // a latched byte waiting on a stall is neither lost nor changed
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !fire) |=> (in_vld_q && $stable(item_q)))
    else $error("waiting byte dropped or changed");

  // line zero, column zero answers offset zero, ok
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_q.first_byte && item_q.target_line == '0 &&
     item_q.target_column == '0)
    |=> (out_vld_q && res_q.byte_offset == '0 && res_q.status == ST_OK))
    else $error("origin request gave a wrong result");

endmodule
